// File: rtl/tcas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcas_pkg
// Shared types, constants and helpers for the ring-road traffic automaton.
// ----------------------------------------------------------------------------
package tcas_pkg;

  localparam int CELLS  = 32;
  localparam int IDX_W  = $clog2(CELLS);
  localparam int SPD_W  = 3;
  localparam int LEN_W  = 6;
  localparam int CNT_W  = 6;
  localparam int ACT_W  = 2;
  localparam int CFG_W  = 6;
  localparam int STEP_W = 3;

  localparam logic [SPD_W-1:0]  SPD_MAX        = '1;
  localparam logic [STEP_W-1:0] STEP_LAST      = 3'd6;
  localparam logic [SPD_W-1:0]  MAX_SPEED_RST  = 3'd5;
  localparam logic [LEN_W-1:0]  ROAD_LEN_RST   = 6'd20;
  localparam logic [LEN_W-1:0]  RING_MIN       = 6'd2;
  localparam logic [LEN_W-1:0]  RING_MAX       = LEN_W'(CELLS);

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK  = 2'd2;

  localparam logic CFG_MAX_SPEED   = 1'b0;
  localparam logic CFG_ROAD_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_WRITE,
    OP_GAP_INIT,
    OP_GAP_STEP,
    OP_CALC,
    OP_MOVE
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_CALC,
    ST_MOVE,
    ST_FIN
  } state_t;

  typedef struct packed {
    cell_op_t         op;
    logic [SPD_W-1:0] vmax;
    logic             wr_occ;
    logic [SPD_W-1:0] wr_spd;
  } cell_ctl_t;

  typedef struct packed {
    cell_op_t op;
    logic     in_stall;
    logic     load_out;
  } ctrl_t;

  function automatic logic [LEN_W-1:0] ring_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = len;
    if (n < RING_MIN) n = RING_MIN;
    if (n > RING_MAX) n = RING_MAX;
    return n;
  endfunction

endpackage
`default_nettype wire

// File: rtl/traffic_cell_automaton_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// traffic_cell_automaton_step
// Ring-road traffic automaton over a row of 32 cells.
// Write and peek items go straight to ST_FIN; tick items run 7 gap-propagation
// steps, 1 speed step and 7 move steps handed cell to cell. ST_FIN loads the
// result once the output register is free; no new item is taken until then.
// Reset (rst_n low, synchronous) empties the road, sets max_speed 5, length 20.
// ----------------------------------------------------------------------------
module traffic_cell_automaton_step (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [tcas_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [tcas_pkg::ACT_W-1:0]  in_action,
  input  wire logic [tcas_pkg::IDX_W-1:0]  in_cell_index,
  input  wire logic                        in_write_occupied,
  input  wire logic [tcas_pkg::SPD_W-1:0]  in_write_speed,
  input  wire logic [tcas_pkg::CELLS-1:0]  in_fast_accel_mask,
  input  wire logic [tcas_pkg::CELLS-1:0]  in_slow_down_mask,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [tcas_pkg::CELLS-1:0]       out_occupancy_mask,
  output logic                             out_cell_occupied,
  output logic [tcas_pkg::SPD_W-1:0]       out_cell_speed,
  output logic [tcas_pkg::CNT_W-1:0]       out_car_count
);
  import tcas_pkg::*;

  logic [SPD_W-1:0] max_speed_r;
  logic [LEN_W-1:0] road_len_r;
  logic [LEN_W-1:0] ring_n;
  logic [IDX_W-1:0] last_idx;

  ctrl_t            ctl;
  cell_ctl_t        cctl;
  logic             in_acc;
  logic [IDX_W-1:0] idx_r;

  logic [CELLS-1:0] has_vec;
  logic [SPD_W-1:0] spd_arr [CELLS];
  logic [SPD_W-1:0] gap_arr [CELLS];
  logic [SPD_W-1:0] rem_arr [CELLS];

  logic             out_valid_r;
  logic [CELLS-1:0] out_mask_r;
  logic             out_occ_r;
  logic [SPD_W-1:0] out_spd_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [CNT_W-1:0] car_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= MAX_SPEED_RST;
      road_len_r  <= ROAD_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_SPEED:   max_speed_r <= cfg_data[SPD_W-1:0];
        CFG_ROAD_LENGTH: road_len_r  <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign ring_n   = ring_len(road_len_r);
  assign last_idx = IDX_W'(ring_n - LEN_W'(1));

  tcas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .out_busy  (out_valid_r && out_stall),
    .ctl       (ctl)
  );

  assign in_stall = ctl.in_stall;
  assign in_acc   = in_valid && !ctl.in_stall;

  always_comb begin
    cctl.op     = ctl.op;
    cctl.vmax   = max_speed_r;
    cctl.wr_occ = in_write_occupied;
    cctl.wr_spd = (in_write_speed > max_speed_r) ? max_speed_r : in_write_speed;
  end

  always_ff @(posedge clk) begin
    if (in_acc) idx_r <= in_cell_index;
  end

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic             ahead_has;
    logic [SPD_W-1:0] ahead_gap;
    logic             behind_has;
    logic [SPD_W-1:0] behind_spd;
    logic [SPD_W-1:0] behind_rem;

    if (i == CELLS - 1) begin : g_wrap_ahead
      assign ahead_has = has_vec[0];
      assign ahead_gap = gap_arr[0];
    end else begin : g_next_ahead
      assign ahead_has = (LEN_W'(i + 1) < ring_n) ? has_vec[i+1] : has_vec[0];
      assign ahead_gap = (LEN_W'(i + 1) < ring_n) ? gap_arr[i+1] : gap_arr[0];
    end

    if (i == 0) begin : g_wrap_behind
      assign behind_has = has_vec[last_idx];
      assign behind_spd = spd_arr[last_idx];
      assign behind_rem = rem_arr[last_idx];
    end else begin : g_prev_behind
      assign behind_has = has_vec[i-1];
      assign behind_spd = spd_arr[i-1];
      assign behind_rem = rem_arr[i-1];
    end

    tcas_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cctl),
      .wr_sel     ((in_cell_index == IDX_W'(i)) && ({1'b0, in_cell_index} < ring_n)),
      .in_ring    (LEN_W'(i) < ring_n),
      .fast_bit   (in_fast_accel_mask[i]),
      .slow_bit   (in_slow_down_mask[i]),
      .ahead_has  (ahead_has),
      .ahead_gap  (ahead_gap),
      .behind_has (behind_has),
      .behind_spd (behind_spd),
      .behind_rem (behind_rem),
      .has_car    (has_vec[i]),
      .speed      (spd_arr[i]),
      .gap        (gap_arr[i]),
      .rem        (rem_arr[i])
    );
  end

  // car count: eight-cell partial sums, then a final add
  always_comb begin
    logic [3:0] part [CELLS/8];
    car_cnt = '0;
    for (int g = 0; g < CELLS / 8; g++) begin
      part[g] = '0;
      for (int k = 0; k < 8; k++) part[g] = part[g] + 4'(has_vec[g*8+k]);
    end
    for (int g = 0; g < CELLS / 8; g++) car_cnt = car_cnt + CNT_W'(part[g]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_mask_r <= has_vec;
      out_occ_r  <= has_vec[idx_r];
      out_spd_r  <= has_vec[idx_r] ? spd_arr[idx_r] : '0;
      out_cnt_r  <= car_cnt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_occupancy_mask = out_mask_r;
  assign out_cell_occupied  = out_occ_r;
  assign out_cell_speed     = out_spd_r;
  assign out_car_count      = out_cnt_r;

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_action == ACT_TICK |=> in_stall)
    else $error("tick accepted but block not busy");

  a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_action == ACT_WRITE && in_write_occupied &&
    ({1'b0, in_cell_index} < ring_n) |=> has_vec[$past(in_cell_index)])
    else $error("accepted write did not place car");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |-> !(out_valid_r && out_stall))
    else $error("result loaded over a waiting result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_cnt_r <= CNT_W'(CELLS))
    else $error("car count out of range");

  a_empty_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_occ_r |-> out_spd_r == '0)
    else $error("empty cell reports speed");

endmodule
`default_nettype wire

// File: rtl/tcas_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcas_cell
// One road cell: car flag and speed, free-gap estimate from the cell ahead,
// and remaining-move count handed from the cell behind.
// ----------------------------------------------------------------------------
module tcas_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire tcas_pkg::cell_ctl_t       ctl,
  input  wire logic                      wr_sel,
  input  wire logic                      in_ring,
  input  wire logic                      fast_bit,
  input  wire logic                      slow_bit,
  input  wire logic                      ahead_has,
  input  wire logic [tcas_pkg::SPD_W-1:0] ahead_gap,
  input  wire logic                      behind_has,
  input  wire logic [tcas_pkg::SPD_W-1:0] behind_spd,
  input  wire logic [tcas_pkg::SPD_W-1:0] behind_rem,
  output logic                           has_car,
  output logic [tcas_pkg::SPD_W-1:0]     speed,
  output logic [tcas_pkg::SPD_W-1:0]     gap,
  output logic [tcas_pkg::SPD_W-1:0]     rem
);
  import tcas_pkg::*;

  logic             has_r, has_nxt;
  logic [SPD_W-1:0] spd_r, spd_nxt;
  logic [SPD_W-1:0] gap_r, gap_nxt;
  logic [SPD_W-1:0] rem_r, rem_nxt;
  logic             fast_r, fast_nxt;
  logic             slow_r, slow_nxt;
  logic [SPD_W:0]   accel;
  logic [SPD_W-1:0] capped;
  logic [SPD_W-1:0] limited;
  logic [SPD_W-1:0] final_v;

  always_comb begin
    accel   = {1'b0, spd_r} + (fast_r ? (SPD_W+1)'(2) : (SPD_W+1)'(1));
    capped  = (accel > {1'b0, ctl.vmax}) ? ctl.vmax : accel[SPD_W-1:0];
    limited = (capped > gap_r) ? gap_r : capped;
    if (slow_r) final_v = (limited > SPD_W'(2)) ? limited - SPD_W'(2) : '0;
    else final_v = limited;
  end

  always_comb begin
    has_nxt  = has_r;
    spd_nxt  = spd_r;
    gap_nxt  = gap_r;
    rem_nxt  = rem_r;
    fast_nxt = fast_r;
    slow_nxt = slow_r;
    case (ctl.op)
      OP_WRITE: begin
        if (wr_sel) begin
          has_nxt = ctl.wr_occ;
          spd_nxt = ctl.wr_occ ? ctl.wr_spd : '0;
        end
      end
      OP_GAP_INIT: begin
        gap_nxt  = SPD_MAX;
        fast_nxt = fast_bit;
        slow_nxt = slow_bit;
      end
      OP_GAP_STEP: begin
        if (ahead_has) gap_nxt = '0;
        else gap_nxt = (ahead_gap == SPD_MAX) ? SPD_MAX : ahead_gap + SPD_W'(1);
      end
      OP_CALC: begin
        if (!in_ring) begin
          has_nxt = 1'b0;
          spd_nxt = '0;
          rem_nxt = '0;
        end else if (has_r) begin
          spd_nxt = final_v;
          rem_nxt = final_v;
        end else begin
          rem_nxt = '0;
        end
      end
      OP_MOVE: begin
        if (in_ring && behind_has && behind_rem != '0) begin
          has_nxt = 1'b1;
          spd_nxt = behind_spd;
          rem_nxt = behind_rem - SPD_W'(1);
        end else if (has_r && rem_r != '0) begin
          has_nxt = 1'b0;
          spd_nxt = '0;
          rem_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_r <= 1'b0;
      spd_r <= '0;
    end else begin
      has_r <= has_nxt;
      spd_r <= spd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gap_r  <= gap_nxt;
    rem_r  <= rem_nxt;
    fast_r <= fast_nxt;
    slow_r <= slow_nxt;
  end

  assign has_car = has_r;
  assign speed   = spd_r;
  assign gap     = gap_r;
  assign rem     = rem_r;

endmodule
`default_nettype wire

// File: rtl/tcas_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcas_ctrl
// Sequencer: takes an item, steps the cell row through gap, speed and move
// phases for a tick, then hands the result to the output register.
// ----------------------------------------------------------------------------
module tcas_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [tcas_pkg::ACT_W-1:0] in_action,
  input  wire logic                      out_busy,
  output tcas_pkg::ctrl_t                ctl
);
  import tcas_pkg::*;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_valid) state_nxt = (in_action == ACT_TICK) ? ST_GAP : ST_FIN;
      end
      ST_GAP: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = ST_CALC;
          step_nxt  = '0;
        end
      end
      ST_CALC: begin
        state_nxt = ST_MOVE;
        step_nxt  = '0;
      end
      ST_MOVE: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = ST_FIN;
          step_nxt  = '0;
        end
      end
      ST_FIN: begin
        if (!out_busy) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  always_comb begin
    ctl.op       = OP_HOLD;
    ctl.in_stall = 1'b1;
    ctl.load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        ctl.in_stall = 1'b0;
        if (in_valid) begin
          if (in_action == ACT_WRITE) ctl.op = OP_WRITE;
          else if (in_action == ACT_TICK) ctl.op = OP_GAP_INIT;
        end
      end
      ST_GAP:  ctl.op = OP_GAP_STEP;
      ST_CALC: ctl.op = OP_CALC;
      ST_MOVE: ctl.op = OP_MOVE;
      ST_FIN:  ctl.load_out = !out_busy;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule
`default_nettype wire
